>>> hw/rtl/chacha_pkg.sv
package chacha_pkg;

	localparam int DATA_W      = 64;
	localparam int COUNT_W     = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int DOUBLE_ROUNDS_DEF = 10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_SALT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_IV   = 3'd5;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	// word indexes a, b, c, d of quarter round q (0..3 columns, 4..7 diagonals)
	function automatic logic [15:0] qr_index(input logic [2:0] q);
		logic [15:0] r;
		case (q)
			3'd0: r = {4'd12, 4'd8,  4'd4, 4'd0};
			3'd1: r = {4'd13, 4'd9,  4'd5, 4'd1};
			3'd2: r = {4'd14, 4'd10, 4'd6, 4'd2};
			3'd3: r = {4'd15, 4'd11, 4'd7, 4'd3};
			3'd4: r = {4'd15, 4'd10, 4'd5, 4'd0};
			3'd5: r = {4'd12, 4'd11, 4'd6, 4'd1};
			3'd6: r = {4'd13, 4'd8,  4'd7, 4'd2};
			3'd7: r = {4'd14, 4'd9,  4'd4, 4'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/chacha20_stream_cipher.sv
// ChaCha20 (IETF, 96-bit nonce) stream cipher on 8-byte beats. The user must
// write key and nonce through the configuration port only while the block is
// idle; the block itself does not enforce this. The first beat of each 64-byte
// keystream block waits for the core: the state is loaded word by word into
// the working memory, then come 8*DOUBLE_ROUNDS quarter rounds, each of four
// reads, two half steps and four writes, with one read and one write port.
// Then come the feed-forward add, the keystream read and the output register.
// The other seven beats of the block go through accept, keystream memory read
// and output register. A beat waiting in the output register does not block
// the input, but the input is not ready again until the beat in process has
// moved into the output register. The block counter restarts at 1 after a
// beat marked tlast.
module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// data_in[63:0], byte_count[67:64], zero pad [71:68]
	input  logic [71:0]                         s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// data_out[63:0], out_byte_count[67:64], zero pad [71:68]
	output logic [71:0]                         m_tdata,
	output logic                                m_tlast
);
	import chacha_pkg::*;

	localparam int RND_W = $clog2(DOUBLE_ROUNDS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_QR   = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [63:0] key_la_q, key_lb_q, key_ha_q, key_hb_q, iv_q;
	logic [31:0] salt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_la_q <= '0; key_lb_q <= '0; key_ha_q <= '0; key_hb_q <= '0;
			iv_q <= '0; salt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW_A:  key_la_q <= cfg_data;
				REG_KEY_LOW_B:  key_lb_q <= cfg_data;
				REG_KEY_HIGH_A: key_ha_q <= cfg_data;
				REG_KEY_HIGH_B: key_hb_q <= cfg_data;
				REG_NONCE_SALT: salt_q <= cfg_data[31:0];
				REG_NONCE_IV:   iv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// initial state word i
	function automatic logic [31:0] init_word(input logic [3:0] i, input logic [31:0] ctr,
			input logic [63:0] la, lb, ha, hb, iv, input logic [31:0] salt);
		logic [31:0] w;
		case (i)
			4'd0: w = SIGMA0;  4'd1: w = SIGMA1;
			4'd2: w = SIGMA2;  4'd3: w = SIGMA3;
			4'd4: w = la[31:0]; 4'd5: w = la[63:32];
			4'd6: w = lb[31:0]; 4'd7: w = lb[63:32];
			4'd8: w = ha[31:0]; 4'd9: w = ha[63:32];
			4'd10: w = hb[31:0]; 4'd11: w = hb[63:32];
			4'd12: w = ctr; 4'd13: w = salt;
			4'd14: w = iv[31:0]; 4'd15: w = iv[63:32];
			default: w = '0;
		endcase
		return w;
	endfunction

	logic [2:0]  state_q;
	logic [31:0] ctr_q;
	logic [2:0]  pos_q;
	logic [3:0]  idx_q;      // load/add word index
	logic [2:0]  qr_q;       // quarter round within double round
	logic [3:0]  qs_q;       // quarter round step
	logic [RND_W-1:0] rnd_q;
	logic        add_v_s1;   // feed-forward read in flight
	logic [3:0]  add_idx_s1;

	logic [63:0] data_q;
	logic [3:0]  cnt_q;
	logic        last_q;

	// working state memory
	logic [31:0] ws_mem [16];
	logic [31:0] ws_rd_q;
	logic [3:0]  ws_ra, ws_wa;
	logic [31:0] ws_wd;
	logic        ws_we;
	// keystream memory, 64-bit rows
	logic [63:0] ks_mem [8];
	logic [63:0] ks_rd_q;
	logic [2:0]  ks_wa;
	logic [63:0] ks_wd;
	logic        ks_we;
	logic [31:0] ks_lo_q;

	// quarter round registers a,b,c,d
	logic [31:0] qa_q, qb_q, qc_q, qd_q;
	logic [15:0] qidx;
	logic [1:0]  rd_sel, cap_sel, wr_sel;
	logic        first_half;
	logic [31:0] ha, hb, hc, hd;

	logic accept, out_go;

	assign qidx = qr_index(qr_q);
	// steps 0..3 read, 1..4 capture, 5 and 6 half steps, 7..10 write back
	assign rd_sel = qs_q[1:0];
	assign cap_sel = qs_q[1:0] - 2'd1;
	assign wr_sel = qs_q[1:0] + 2'd1;
	assign first_half = (qs_q == 4'd5);

	// one half of a quarter round
	always_comb begin
		ha = qa_q + qb_q;
		hd = qd_q ^ ha;
		hd = first_half ? {hd[15:0], hd[31:16]} : {hd[23:0], hd[31:24]};
		hc = qc_q + hd;
		hb = qb_q ^ hc;
		hb = first_half ? {hb[19:0], hb[31:20]} : {hb[24:0], hb[31:25]};
	end

	always_ff @(posedge clk) begin
		if (ws_we) ws_mem[ws_wa] <= ws_wd;
		ws_rd_q <= ws_mem[ws_ra];
		if (ks_we) ks_mem[ks_wa] <= ks_wd;
		ks_rd_q <= ks_mem[pos_q];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_go = !m_tvalid || m_tready;

	// memory port control
	always_comb begin
		ws_ra = idx_q; ws_wa = idx_q; ws_we = 1'b0;
		ws_wd = init_word(idx_q, ctr_q, key_la_q, key_lb_q, key_ha_q,
			key_hb_q, iv_q, salt_q);
		ks_wa = add_idx_s1[3:1];
		ks_wd = {ws_rd_q + init_word(add_idx_s1, ctr_q, key_la_q, key_lb_q,
			key_ha_q, key_hb_q, iv_q, salt_q), ks_lo_q};
		ks_we = 1'b0;
		case (state_q)
			ST_LOAD: ws_we = 1'b1;
			ST_QR: begin
				ws_ra = qidx[{rd_sel, 2'b00} +: 4];
				ws_wa = qidx[{wr_sel, 2'b00} +: 4];
				ws_we = (qs_q >= 4'd7);
				case (wr_sel)
					2'd0: ws_wd = qa_q;
					2'd1: ws_wd = qb_q;
					2'd2: ws_wd = qc_q;
					default: ws_wd = qd_q;
				endcase
			end
			ST_ADD: begin
				ks_we = add_v_s1 && add_idx_s1[0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; ctr_q <= 32'd1; pos_q <= '0; idx_q <= '0;
			qr_q <= '0; qs_q <= '0; rnd_q <= '0; add_v_s1 <= 1'b0; add_idx_s1 <= '0;
			m_tvalid <= 1'b0; m_tdata <= '0; m_tlast <= 1'b0;
			data_q <= '0; cnt_q <= '0; last_q <= 1'b0; ks_lo_q <= '0;
			qa_q <= '0; qb_q <= '0; qc_q <= '0; qd_q <= '0;
		end else begin
			// raise on a new result, drop once taken
			if (state_q == ST_OUT && out_go) m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					data_q <= s_tdata[63:0];
					cnt_q <= (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
					last_q <= s_tlast;
					idx_q <= '0;
					state_q <= (pos_q == 3'd0) ? ST_LOAD : ST_RD;
				end
				ST_LOAD: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd15) begin
						state_q <= ST_QR; qr_q <= '0; qs_q <= '0; rnd_q <= '0;
					end
				end
				ST_QR: begin
					// capture a, b, c, d in the step after each read
					if (qs_q inside {[4'd1:4'd4]}) begin
						case (cap_sel)
							2'd0: qa_q <= ws_rd_q;
							2'd1: qb_q <= ws_rd_q;
							2'd2: qc_q <= ws_rd_q;
							default: qd_q <= ws_rd_q;
						endcase
					end
					if (qs_q inside {4'd5, 4'd6}) begin
						qa_q <= ha; qb_q <= hb; qc_q <= hc; qd_q <= hd;
					end
					// advance; all writes land before the next quarter round reads
					if (qs_q == 4'd10) begin
						qs_q <= '0;
						qr_q <= qr_q + 3'd1;
						if (qr_q == 3'd7) begin
							rnd_q <= rnd_q + RND_W'(1);
							if (rnd_q == RND_W'(DOUBLE_ROUNDS - 1)) begin
								state_q <= ST_ADD; idx_q <= '0;
							end
						end
					end else begin
						qs_q <= qs_q + 4'd1;
					end
				end
				ST_ADD: begin
					add_v_s1 <= (idx_q != 4'd0) || !add_v_s1;
					add_idx_s1 <= idx_q;
					if (idx_q != 4'd0 || !add_v_s1)
						idx_q <= idx_q + 4'd1;
					if (add_v_s1 && !add_idx_s1[0])
						ks_lo_q <= ws_rd_q + init_word(add_idx_s1, ctr_q, key_la_q,
							key_lb_q, key_ha_q, key_hb_q, iv_q, salt_q);
					if (add_v_s1 && add_idx_s1 == 4'd15)
						state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_OUT;
				ST_OUT: if (out_go) begin
					m_tdata <= {4'd0, cnt_q, (data_q ^ ks_rd_q) &
						((cnt_q == 4'd8) ? {64{1'b1}} : ((64'd1 << {cnt_q, 3'd0}) - 64'd1))};
					m_tlast <= last_q;
					state_q <= ST_IDLE;
					if (last_q) begin
						pos_q <= '0; ctr_q <= 32'd1;
					end else begin
						pos_q <= pos_q + 3'd1;
						if (pos_q == 3'd7) ctr_q <= ctr_q + 32'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/chacha_checker.sv
module chacha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tlast
);
	// hold output beat while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// count never above eight
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[67:64] <= 4'd8)
		else $error("byte count above eight");

	// with a byte count of zero, all data bytes are zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67:64] == 4'd0 |-> m_tdata[63:0] == 64'd0)
		else $error("invalid bytes not cleared");

	// one item in flight at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat accepted while busy");
endmodule

bind chacha20_stream_cipher chacha_checker u_chacha_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
